// File: rtl/button_click_classifier_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button click classifier
// Shared helpers for the concurrent checks in the RTL files.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BCC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Types and constants shared by the button click classifier modules.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int NUM_KEYS  = 2;
  localparam int KEY_W     = 1;
  localparam int KEY_SLOTS = 2 ** KEY_W;
  localparam int CNT_W     = 16;
  localparam int CLICK_W   = 3;

  localparam logic [CNT_W-1:0]   CNT_MAX    = '1;
  localparam logic [CLICK_W-1:0] CLICK_SAT  = 3'd4;
  localparam logic [1:0]         MASK_RST   = 2'd1;
  localparam logic [CNT_W-1:0]   LONG_RST   = 16'd200;
  localparam logic [CNT_W-1:0]   GAP_RST    = 16'd50;

  // Event queue depth
  localparam int QDEPTH = 3;

  typedef enum logic [1:0] {
    CFG_MASK = 2'd0,
    CFG_LONG = 2'd1,
    CFG_GAP  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE         = 2'd0,
    PH_PRESSED      = 2'd1,
    PH_WAIT_RELEASE = 2'd2,
    PH_WAIT_CLICK   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_SHORT  = 2'd0,
    EV_DOUBLE = 2'd1,
    EV_TRIPLE = 2'd2,
    EV_LONG   = 2'd3
  } ev_code_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic             raw_level;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] event_key;
    logic [1:0]       event_code;
  } out_item_t;

  // Per-key record held in the state memory
  typedef struct packed {
    phase_t             phase;
    logic [CNT_W-1:0]   hold;
    logic [CLICK_W-1:0] clicks;
    logic [CNT_W-1:0]   gap;
  } key_rec_t;

  typedef struct packed {
    logic [CNT_W-1:0] long_ticks;
    logic [CNT_W-1:0] gap_ticks;
  } limits_t;

  typedef struct packed {
    logic     valid;
    ev_code_t code;
  } key_event_t;

endpackage

// File: rtl/bcc_state_mem.sv
// ----------------------------------------------------------------------------
// bcc_state_mem
// Per-key state memory, one write and one registered read port, with a valid
// bit per entry so that unwritten entries read as the reset record.
// ----------------------------------------------------------------------------
module bcc_state_mem
  import bcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [KEY_W-1:0] waddr,
  input  key_rec_t         wdata,
  input  logic             re,
  input  logic [KEY_W-1:0] raddr,
  output key_rec_t         rdata
);

  key_rec_t             mem [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] valid_r;
  key_rec_t             rd_data_r;
  logic                 rd_valid_r;

  // Write the record
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Track written entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r  <= mem[raddr];
      rd_valid_r <= valid_r[raddr];
    end
  end

  // Unwritten entries read as the reset record
  assign rdata = rd_valid_r ? rd_data_r : '0;

endmodule

// File: rtl/bcc_key_fsm.sv
// ----------------------------------------------------------------------------
// bcc_key_fsm
// Next-state and event logic for one key record and one tick sample.
// ----------------------------------------------------------------------------
module bcc_key_fsm
  import bcc_pkg::*;
(
  input  key_rec_t   cur,
  input  logic       pressed,
  input  limits_t    lim,
  output key_rec_t   nxt,
  output key_event_t ev
);

  logic [CNT_W-1:0] hold_inc;
  logic [CNT_W-1:0] gap_inc;
  logic             long_hit;
  logic             gap_hit;

  // Saturating counters and limit compares
  always_comb begin
    hold_inc = (cur.hold == CNT_MAX) ? CNT_MAX : cur.hold + 1'b1;
    gap_inc  = (cur.gap == CNT_MAX) ? CNT_MAX : cur.gap + 1'b1;
    long_hit = hold_inc >= lim.long_ticks;
    gap_hit  = gap_inc >= lim.gap_ticks;
  end

  // Next state of the record
  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_IDLE: begin
        if (pressed) begin
          nxt.phase = PH_PRESSED;
          nxt.hold  = '0;
        end
      end
      PH_PRESSED: begin
        if (pressed) begin
          nxt.hold = hold_inc;
          if (long_hit) begin
            nxt.phase  = PH_WAIT_RELEASE;
            nxt.hold   = '0;
            nxt.clicks = '0;
          end
        end else begin
          if (cur.clicks < CLICK_SAT) begin
            nxt.clicks = cur.clicks + 1'b1;
          end
          nxt.phase = PH_WAIT_CLICK;
          nxt.gap   = '0;
        end
      end
      PH_WAIT_RELEASE: begin
        if (!pressed) begin
          nxt.phase = PH_IDLE;
        end
      end
      default: begin
        nxt.gap = gap_inc;
        if (pressed) begin
          nxt.phase = PH_PRESSED;
          nxt.hold  = '0;
          nxt.gap   = '0;
        end else if (gap_hit) begin
          nxt.phase  = PH_IDLE;
          nxt.clicks = '0;
          nxt.gap    = '0;
        end
      end
    endcase
  end

  // Event output
  always_comb begin
    ev.valid = 1'b0;
    ev.code  = EV_SHORT;
    case (cur.phase)
      PH_PRESSED: begin
        if (pressed && long_hit) begin
          ev.valid = 1'b1;
          ev.code  = EV_LONG;
        end
      end
      PH_WAIT_CLICK: begin
        if (!pressed && gap_hit) begin
          case (cur.clicks)
            3'd1: begin
              ev.valid = 1'b1;
              ev.code  = EV_SHORT;
            end
            3'd2: begin
              ev.valid = 1'b1;
              ev.code  = EV_DOUBLE;
            end
            3'd3: begin
              ev.valid = 1'b1;
              ev.code  = EV_TRIPLE;
            end
            default: begin
              ev.valid = 1'b0;
            end
          endcase
        end
      end
      default: begin
        ev.valid = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/bcc_event_fifo.sv
// ----------------------------------------------------------------------------
// bcc_event_fifo
// Small event queue between the update stage and the result channel.
// ----------------------------------------------------------------------------
module bcc_event_fifo
  import bcc_pkg::*;
`include "button_click_classifier_unit_macros.svh"
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  output logic [1:0] count
);

  out_item_t  q [QDEPTH];
  logic [1:0] head_r, head_nxt;
  logic [1:0] tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = cnt_r != 2'd0;
  assign pop       = out_valid && !out_stall;
  assign out_data  = q[head_r];
  assign count     = cnt_r;

  // Advance pointers, wrapping at the queue depth
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (pop) begin
      head_nxt = (head_r == 2'(QDEPTH - 1)) ? 2'd0 : head_r + 2'd1;
    end
    if (push) begin
      tail_nxt = (tail_r == 2'(QDEPTH - 1)) ? 2'd0 : tail_r + 2'd1;
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the pushed event
  always_ff @(posedge clk) begin
    if (push) begin
      q[tail_r] <= push_data;
    end
  end

  `BCC_ASSERT_IMPL(a_no_overflow, clk, rst_n, push && !pop, cnt_r < 2'(QDEPTH), "event queue overflow")
  `BCC_ASSERT_NEXT(a_push_count, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 2'd1, "push lost")
  `BCC_ASSERT_IMPL(a_depth, clk, rst_n, 1'b1, cnt_r <= 2'(QDEPTH), "queue count beyond depth")

endmodule

// File: rtl/button_click_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// Per-key click and long-press classifier over a key state memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one tick sample (key index, raw pin level) per transfer.
//   out_* : one event (key, code) per transfer; codes are short, double,
//           triple click and long press. Most samples give no event.
//   cfg_* : register writes (polarity mask, long-press and gap limits),
//           always ready; write only while the block is idle.
// Path: a sample is registered in the read stage; its event is then queued.
// Throughput: one sample per cycle while in_stall is low. Each sample
//   reads its key record from the state memory and writes it back in the
//   next cycle; a same-key sample right behind gets it via a bypass register.
// Reset: all keys idle with cleared counters (per-entry valid bits in the
//   memory), registers to their defaults, event queue empty.
// Stall: events wait in a three-entry queue; in_stall rises only when the
//   queue and the update stage together could fill it.
// ----------------------------------------------------------------------------
module button_click_classifier_unit
  import bcc_pkg::*;
`include "button_click_classifier_unit_macros.svh"
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [1:0]       mask_r;
  logic [CNT_W-1:0] long_r;
  logic [CNT_W-1:0] gap_r;
  limits_t          lim;

  logic             in_xfer;
  logic             key_ok;
  logic             s1_valid_r;
  logic [KEY_W-1:0] s1_key_r;
  logic             s1_pressed_r;
  logic             fwd_r;
  key_rec_t         fwd_data_r;
  key_rec_t         mem_rdata;
  key_rec_t         s1_cur;
  key_rec_t         s1_nxt;
  key_event_t       s1_ev;
  logic [1:0]       q_count;
  out_item_t        push_data;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RST;
      long_r <= LONG_RST;
      gap_r  <= GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MASK: mask_r <= cfg_data[1:0];
        CFG_LONG: long_r <= cfg_data;
        CFG_GAP:  gap_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign lim.long_ticks = long_r;
  assign lim.gap_ticks  = gap_r;

  // Hold input while the event queue could overflow
  assign in_stall = ({1'b0, q_count} + {2'b0, s1_valid_r}) > 3'(QDEPTH - 1);
  assign in_xfer  = in_valid && !in_stall;
  assign key_ok   = int'(in_data.key_index) < NUM_KEYS;

  // Read stage: issue the read, note a same-key bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer && key_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_key_r     <= in_data.key_index;
      s1_pressed_r <= in_data.raw_level == mask_r[in_data.key_index];
      fwd_r        <= s1_valid_r && (s1_key_r == in_data.key_index);
      fwd_data_r   <= s1_nxt;
    end
  end

  bcc_state_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (s1_valid_r),
    .waddr (s1_key_r),
    .wdata (s1_nxt),
    .re    (in_xfer),
    .raddr (in_data.key_index),
    .rdata (mem_rdata)
  );

  // Update stage: pick forwarded or stored record, write back
  assign s1_cur = fwd_r ? fwd_data_r : mem_rdata;

  bcc_key_fsm u_fsm (
    .cur     (s1_cur),
    .pressed (s1_pressed_r),
    .lim     (lim),
    .nxt     (s1_nxt),
    .ev      (s1_ev)
  );

  assign push_data.event_key  = s1_key_r;
  assign push_data.event_code = s1_ev.code;

  bcc_event_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r && s1_ev.valid),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (q_count)
  );

  `BCC_ASSERT_NEXT(a_accept_update, clk, rst_n, in_xfer && key_ok, s1_valid_r, "sample lost")
  `BCC_ASSERT_IMPL(a_long_phase, clk, rst_n, s1_valid_r && s1_ev.valid && (s1_ev.code == EV_LONG), s1_nxt.phase == PH_WAIT_RELEASE && s1_nxt.clicks == '0, "long press state")
  `BCC_ASSERT_NEXT(a_fwd_key, clk, rst_n, in_xfer && s1_valid_r && (s1_key_r == in_data.key_index), fwd_r && fwd_data_r == $past(s1_nxt), "bypass missed")

endmodule
